// File: rtl/core/gdfs_pkg.sv
`timescale 1ns / 1ps
// gdfs_pkg: shared types and codes for the depth-first search postorder block
// no dependencies; imported by gdfs_ctrl, gdfs_dp, graph_dfs_postorder and tb
package gdfs_pkg;

    // node_count register width, fixed by the register map
    localparam int CNT_W = 7;

    // item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_START = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_ACCEPT = 2'd0;
    localparam logic [1:0] STATUS_REFUSE = 2'd1;
    localparam logic [1:0] STATUS_FINISH = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_LINK,
        ST_EMIT_OK,
        ST_EMIT_BAD,
        ST_ROOT,
        ST_HEAD,
        ST_EDGE,
        ST_TGT,
        ST_POP
    } gdfs_state_t;

    typedef struct packed {
        logic       take_add;   // store new edge, read tail of source list
        logic       init;       // clear visit bits, time and root
        logic       link;       // hook new edge onto source list
        logic       emit;       // load output register
        logic [1:0] emit_code;
        logic       root_inc;
        logic       open_root;
        logic       load_head;
        logic       edge_read;
        logic       advance;
        logic       push;
        logic       finish;
        logic       pop_load;
    } gdfs_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic out_free;
        logic root_end;
        logic root_seen;
        logic cursor_null;
        logic child_new;
        logic depth_one;
        logic last_node;
    } gdfs_sts_t;

endpackage

// File: rtl/core/gdfs_ctrl.sv
`timescale 1ns / 1ps
// gdfs_ctrl: sequencer for edge insertion and the stack-based search walk
// depends on gdfs_pkg; drives gdfs_dp through gdfs_cmd_t
module gdfs_ctrl
    import gdfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  gdfs_sts_t   sts,
    output gdfs_cmd_t   cmd,
    output gdfs_state_t state
);

    gdfs_state_t state_reg;
    gdfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_START)
                        state_next = ST_ROOT;
                    else if (sts.add_ok)
                        state_next = ST_ADD_LINK;
                    else if (!sts.out_free)
                        state_next = ST_EMIT_BAD;
                end
            end
            ST_ADD_LINK:
                state_next = sts.out_free ? ST_IDLE : ST_EMIT_OK;
            ST_EMIT_OK,
            ST_EMIT_BAD:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            ST_ROOT:
            begin
                if (sts.root_end)
                    state_next = ST_IDLE;
                else if (!sts.root_seen)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
                state_next = ST_EDGE;
            ST_EDGE:
            begin
                if (!sts.cursor_null)
                    state_next = ST_TGT;
                else if (sts.out_free)
                begin
                    if (sts.last_node)
                        state_next = ST_IDLE;
                    else if (sts.depth_one)
                        state_next = ST_ROOT;
                    else
                        state_next = ST_POP;
                end
            end
            ST_TGT:
                state_next = sts.child_new ? ST_HEAD : ST_EDGE;
            ST_POP:
                state_next = ST_EDGE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (kind == KIND_START)
                        cmd.init = 1'b1;
                    else if (sts.add_ok)
                        cmd.take_add = 1'b1;
                    else if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = STATUS_REFUSE;
                    end
                end
            end
            ST_ADD_LINK:
            begin
                cmd.link      = 1'b1;
                cmd.emit      = sts.out_free;
                cmd.emit_code = STATUS_ACCEPT;
            end
            ST_EMIT_OK:
            begin
                cmd.emit      = sts.out_free;
                cmd.emit_code = STATUS_ACCEPT;
            end
            ST_EMIT_BAD:
            begin
                cmd.emit      = sts.out_free;
                cmd.emit_code = STATUS_REFUSE;
            end
            ST_ROOT:
            begin
                if (!sts.root_end)
                begin
                    cmd.root_inc  = sts.root_seen;
                    cmd.open_root = !sts.root_seen;
                end
            end
            ST_HEAD:
                cmd.load_head = 1'b1;
            ST_EDGE:
            begin
                if (!sts.cursor_null)
                    cmd.edge_read = 1'b1;
                else if (sts.out_free)
                begin
                    cmd.finish    = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_code = STATUS_FINISH;
                end
            end
            ST_TGT:
            begin
                cmd.push    = sts.child_new;
                cmd.advance = !sts.child_new;
            end
            ST_POP:
                cmd.pop_load = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule

// File: rtl/core/gdfs_dp.sv
`timescale 1ns / 1ps
// gdfs_dp: edge store, adjacency lists, search stack, time counter, output register
// depends on gdfs_pkg; commanded by gdfs_ctrl
module gdfs_dp
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [5:0]  src_node,
    input  logic [5:0]  dst_node,
    input  gdfs_cmd_t   cmd,
    output gdfs_sts_t   sts,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [5:0]  node,
    output logic [7:0]  discover_time,
    output logic [7:0]  finish_time,
    output logic        last
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam int SW = NW + EW + 8;
    localparam logic [EW-1:0]    EDGE_NULL = EW'(MAX_EDGES);
    localparam logic [CNT_W-1:0] NODE_MAX  = CNT_W'(MAX_NODES);

    // memories
    logic [NW-1:0] tgt_mem  [MAX_EDGES];
    logic [EW-1:0] nxt_mem  [MAX_EDGES];
    logic [EW-1:0] head_mem [MAX_NODES];
    logic [EW-1:0] tail_mem [MAX_NODES];
    logic [SW-1:0] stk_mem  [MAX_NODES];

    logic [NW-1:0] tgt_rd_reg;
    logic [EW-1:0] nxt_rd_reg;
    logic [EW-1:0] head_rd_reg;
    logic [EW-1:0] tail_rd_reg;
    logic [SW-1:0] stk_rd_reg;

    // control state
    logic [CNT_W-1:0]     node_count_reg;
    logic [EW-1:0]        used_reg;
    logic [MAX_NODES-1:0] has_edges_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [7:0]           time_reg;
    logic [CNT_W-1:0]     root_reg;
    logic [DW-1:0]        depth_reg;

    // top of stack and captured source
    logic [NW-1:0] top_node_reg;
    logic [EW-1:0] cur_reg;
    logic [7:0]    top_dtime_reg;
    logic [NW-1:0] src_reg;

    // output register
    logic       result_valid_reg;
    logic [1:0] status_reg;
    logic [5:0] node_reg;
    logic [7:0] dtime_reg;
    logic [7:0] ftime_reg;
    logic       last_reg;

    logic [CNT_W-1:0] n_eff;
    logic [7:0]       time_next;
    logic [DW-1:0]    depth_m1;
    logic [DW-1:0]    depth_m2;
    logic             cfg_write;
    logic             nxt_we;
    logic [EA-1:0]    nxt_wa;
    logic [EW-1:0]    nxt_wd;
    logic             head_re;
    logic [NW-1:0]    head_ra;

    // node count clamped into 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (node_count_reg > NODE_MAX)
            n_eff = NODE_MAX;
        else
            n_eff = node_count_reg;
    end

    assign time_next = time_reg + 8'd1;
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count_reg} : 32'd0;

    // edge store: new entry on take, link of old tail on link
    assign nxt_we = cmd.take_add || (cmd.link && has_edges_reg[src_reg]);
    assign nxt_wa = cmd.take_add ? used_reg[EA-1:0] : tail_rd_reg[EA-1:0];
    assign nxt_wd = cmd.take_add ? EDGE_NULL : used_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_add)
            tgt_mem[used_reg[EA-1:0]] <= dst_node[NW-1:0];
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        if (cmd.edge_read)
        begin
            tgt_rd_reg <= tgt_mem[cur_reg[EA-1:0]];
            nxt_rd_reg <= nxt_mem[cur_reg[EA-1:0]];
        end
    end

    // list heads and tails; has_edges_reg tells which entries hold data
    assign head_re = cmd.open_root || cmd.push;
    assign head_ra = cmd.open_root ? root_reg[NW-1:0] : tgt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.link && !has_edges_reg[src_reg])
            head_mem[src_reg] <= used_reg;
        if (cmd.link)
            tail_mem[src_reg] <= used_reg;
        if (cmd.take_add)
            tail_rd_reg <= tail_mem[src_node[NW-1:0]];
        if (head_re)
            head_rd_reg <= head_mem[head_ra];
    end

    // search stack below the top entry
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stk_mem[depth_m1[NW-1:0]] <= {top_node_reg, nxt_rd_reg, top_dtime_reg};
        if (cmd.finish)
            stk_rd_reg <= stk_mem[depth_m2[NW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(1);
            used_reg       <= '0;
            has_edges_reg  <= '0;
            visited_reg    <= '0;
            time_reg       <= '0;
            root_reg       <= '0;
            depth_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
                node_count_reg <= pwdata[CNT_W-1:0];
            if (cmd.link)
            begin
                used_reg               <= used_reg + EW'(1);
                has_edges_reg[src_reg] <= 1'b1;
            end
            if (cmd.init)
            begin
                visited_reg <= '0;
                time_reg    <= '0;
                root_reg    <= '0;
            end
            if (cmd.root_inc)
                root_reg <= root_reg + CNT_W'(1);
            if (cmd.open_root)
            begin
                visited_reg[root_reg[NW-1:0]] <= 1'b1;
                time_reg  <= time_next;
                depth_reg <= DW'(1);
            end
            if (cmd.push)
            begin
                visited_reg[tgt_rd_reg] <= 1'b1;
                time_reg  <= time_next;
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.finish)
            begin
                time_reg  <= time_next;
                depth_reg <= depth_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_add)
            src_reg <= src_node[NW-1:0];
        if (cmd.open_root)
        begin
            top_node_reg  <= root_reg[NW-1:0];
            top_dtime_reg <= time_next;
        end
        if (cmd.load_head)
            cur_reg <= has_edges_reg[top_node_reg] ? head_rd_reg : EDGE_NULL;
        if (cmd.advance)
            cur_reg <= nxt_rd_reg;
        if (cmd.push)
        begin
            top_node_reg  <= tgt_rd_reg;
            top_dtime_reg <= time_next;
        end
        if (cmd.pop_load)
            {top_node_reg, cur_reg, top_dtime_reg} <= stk_rd_reg;
    end

    // status toward the controller
    always_comb
    begin
        sts.add_ok      = ({1'b0, src_node} < n_eff) && ({1'b0, dst_node} < n_eff)
                          && (used_reg != EDGE_NULL);
        sts.out_free    = !result_valid_reg || !result_stall;
        sts.root_end    = root_reg >= n_eff;
        sts.root_seen   = visited_reg[root_reg[NW-1:0]];
        sts.cursor_null = cur_reg == EDGE_NULL;
        sts.child_new   = (CNT_W'(tgt_rd_reg) < n_eff) && !visited_reg[tgt_rd_reg];
        sts.depth_one   = depth_reg == DW'(1);
        // every node takes two time steps, so the run ends at time 2n
        sts.last_node   = time_next == {n_eff, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_code;
            if (cmd.emit_code == STATUS_FINISH)
            begin
                node_reg  <= 6'(top_node_reg);
                dtime_reg <= top_dtime_reg;
                ftime_reg <= time_next;
                last_reg  <= sts.last_node;
            end
            else
            begin
                node_reg  <= '0;
                dtime_reg <= '0;
                ftime_reg <= '0;
                last_reg  <= 1'b0;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign node          = node_reg;
    assign discover_time = dtime_reg;
    assign finish_time   = ftime_reg;
    assign last          = last_reg;

endmodule

// File: rtl/core/graph_dfs_postorder.sv
`timescale 1ns / 1ps
// edge add: output loaded in the link state (with the transaction itself if refused); next item
//   taken once the link state is done (straight from idle if refused); a stalled output delays both
// start: one report per node; each stored edge of an in-range node costs an edge store read
//   and a target check, and output stalls lengthen the run
// reset: edge store empty, all lists null, node_count 1, output empty; edge and stack
//   memories are not cleared
module graph_dfs_postorder
    import gdfs_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [5:0]  src_node,
    input  logic [5:0]  dst_node,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [5:0]  node,
    output logic [7:0]  discover_time,
    output logic [7:0]  finish_time,
    output logic        last
);

    gdfs_cmd_t   cmd;
    gdfs_sts_t   sts;
    gdfs_state_t state;

    gdfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .kind       (kind),
        .sts        (sts),
        .cmd        (cmd),
        .state      (state)
    );

    gdfs_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .src_node      (src_node),
        .dst_node      (dst_node),
        .cmd           (cmd),
        .sts           (sts),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .node          (node),
        .discover_time (discover_time),
        .finish_time   (finish_time),
        .last          (last)
    );

    // a node always finishes after it was discovered
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_FINISH) |-> (finish_time > discover_time))
        else $error("finish time not after discovery time");

    // the end-of-run mark only rides on node reports
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (status == STATUS_FINISH))
        else $error("last set on an edge transaction result");

    // the sequencer leaves idle only on an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_IDLE && !item_valid) |=> (state == ST_IDLE))
        else $error("left idle without an input transaction");

    // a pop always follows a finish in the edge step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_POP) |-> ($past(state) == ST_EDGE))
        else $error("stack pop without a preceding finish");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for graph_dfs_postorder, edge loading and postorder search reports
// depends on gdfs_pkg and the graph_dfs_postorder rtl; carries its own search predictor
module tb;
    import gdfs_pkg::*;

    localparam int NODE_SLOTS = 64;
    localparam int EDGE_SLOTS = 256;
    localparam logic [8:0] LINK_NULL = 9'd256;
    localparam logic [2:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       k;
        logic [5:0] s;
        logic [5:0] d;
    } graph_item_t;

    typedef struct packed {
        logic [1:0] st;
        logic [5:0] nd;
        logic [7:0] dtime;
        logic [7:0] ftime;
        logic       lst;
    } graph_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        kind = KIND_ADD;
    logic [5:0]  src_node = '0;
    logic [5:0]  dst_node = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  status;
    logic [5:0]  node;
    logic [7:0]  discover_time;
    logic [7:0]  finish_time;
    logic        last;

    graph_dfs_postorder dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall),
        .kind(kind), .src_node(src_node), .dst_node(dst_node),
        .result_valid(result_valid), .result_stall(result_stall),
        .status(status), .node(node), .discover_time(discover_time),
        .finish_time(finish_time), .last(last)
    );

    always #4 clk = ~clk;

    graph_item_t   items_to_send[$];
    graph_report_t reports_due[$];

    int  send_idle_pct = 38;
    int  recv_idle_pct = 46;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    int  hold_left = 0;
    logic took_item = 1'b0;
    int  cycle_count = 0;
    int  mismatches = 0;
    int  items_taken = 0;
    int  edges_kept = 0;
    int  edges_refused = 0;
    int  finish_reports = 0;
    int  searches = 0;

    // predictor state
    logic [5:0] m_edge_dst  [EDGE_SLOTS];
    logic [8:0] m_edge_link [EDGE_SLOTS];
    logic [8:0] m_first [NODE_SLOTS];
    logic [8:0] m_final [NODE_SLOTS];
    int         m_used;
    logic [1:0] m_mark [NODE_SLOTS];
    logic [7:0] m_disc [NODE_SLOTS];
    logic [5:0] m_stk_node [NODE_SLOTS];
    logic [8:0] m_stk_cur  [NODE_SLOTS];
    logic [7:0] m_time;
    logic [6:0] m_count_reg;

    function automatic int live_nodes();
        if (m_count_reg == 7'd0)
            return 1;
        if (int'(m_count_reg) > NODE_SLOTS)
            return NODE_SLOTS;
        return int'(m_count_reg);
    endfunction

    task automatic append_report(input graph_report_t r);
        reports_due.insert(reports_due.size(), r);
    endtask

    task automatic append_item(input graph_item_t it);
        items_to_send.insert(items_to_send.size(), it);
    endtask

    task automatic reset_model();
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            m_first[i] = LINK_NULL;
            m_final[i] = LINK_NULL;
            m_mark[i]  = 2'd0;
        end
        m_used = 0;
        m_time = 8'd0;
        m_count_reg = 7'd1;
    endtask

    task automatic predict_edge_add(input logic [5:0] s, input logic [5:0] d);
        graph_report_t r;
        int n;
        n = live_nodes();
        r = '0;
        if (int'(s) >= n || int'(d) >= n || m_used >= EDGE_SLOTS)
        begin
            r.st = STATUS_REFUSE;
        end
        else
        begin
            m_edge_dst[m_used]  = d;
            m_edge_link[m_used] = LINK_NULL;
            if (m_final[s] == LINK_NULL)
                m_first[s] = 9'(m_used);
            else
                m_edge_link[m_final[s]] = 9'(m_used);
            m_final[s] = 9'(m_used);
            m_used++;
            r.st = STATUS_ACCEPT;
        end
        append_report(r);
    endtask

    task automatic open_node_model(input int v, inout int depth);
        m_time = m_time + 8'd1;
        m_disc[v] = m_time;
        m_mark[v] = 2'd1;
        if (depth < NODE_SLOTS)
        begin
            m_stk_node[depth] = 6'(v);
            m_stk_cur[depth]  = m_first[v];
            depth++;
        end
    endtask

    task automatic predict_postorder();
        graph_report_t held;
        graph_report_t r;
        logic [8:0] cur;
        bit have;
        int n;
        int depth;
        int top;
        int t;
        int v;
        n = live_nodes();
        have = 1'b0;
        held = '0;
        for (int i = 0; i < NODE_SLOTS; i++)
            m_mark[i] = 2'd0;
        m_time = 8'd0;
        for (int root = 0; root < n; root++)
        begin
            if (m_mark[root] == 2'd0)
            begin
                depth = 0;
                open_node_model(root, depth);
                while (depth > 0)
                begin
                    top = depth - 1;
                    cur = m_stk_cur[top];
                    if (cur < LINK_NULL)
                    begin
                        t = int'(m_edge_dst[cur]);
                        m_stk_cur[top] = m_edge_link[cur];
                        // targets beyond the current count are skipped
                        if (t < n && m_mark[t] == 2'd0)
                            open_node_model(t, depth);
                    end
                    else
                    begin
                        v = int'(m_stk_node[top]);
                        depth = top;
                        m_mark[v] = 2'd2;
                        m_time = m_time + 8'd1;
                        r.st = STATUS_FINISH;
                        r.nd = 6'(v);
                        r.dtime = m_disc[v];
                        r.ftime = m_time;
                        r.lst = 1'b0;
                        if (have)
                            append_report(held);
                        held = r;
                        have = 1'b1;
                    end
                end
            end
        end
        if (have)
        begin
            held.lst = 1'b1;
            append_report(held);
        end
    endtask

    // driver: next transaction presented at the falling edge
    always @(negedge clk)
    begin
        if (!item_valid || took_item)
        begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                graph_item_t it;
                it = items_to_send.pop_front();
                item_valid <= 1'b1;
                kind <= it.k;
                src_node <= it.s;
                dst_node <= it.d;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        graph_report_t got;
        graph_report_t want;
        took_item <= item_valid && !item_stall && rst_n;
        if (rst_n && result_valid && !result_stall)
        begin
            got.st = status;
            got.nd = node;
            got.dtime = discover_time;
            got.ftime = finish_time;
            got.lst = last;
            if (got.st == STATUS_FINISH)
                finish_reports++;
            if (reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d nd=%0d dt=%0d ft=%0d lst=%0d",
                             got.st, got.nd, got.dtime, got.ftime, got.lst);
            end
            else
            begin
                want = reports_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected st=%0d nd=%0d dt=%0d ft=%0d lst=%0d",
                                 want.st, want.nd, want.dtime, want.ftime, want.lst);
                        $display("          actual   st=%0d nd=%0d dt=%0d ft=%0d lst=%0d",
                                 got.st, got.nd, got.dtime, got.ftime, got.lst);
                    end
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            items_taken++;
            if (kind == KIND_ADD)
            begin
                if (int'(src_node) < live_nodes() && int'(dst_node) < live_nodes()
                    && m_used < EDGE_SLOTS)
                    edges_kept++;
                else
                    edges_refused++;
                predict_edge_add(src_node, dst_node);
            end
            else
            begin
                searches++;
                predict_postorder();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_edge(input int s, input int d);
        graph_item_t it;
        it.k = KIND_ADD;
        it.s = 6'(s);
        it.d = 6'(d);
        append_item(it);
    endtask

    task automatic send_start();
        graph_item_t it;
        it.k = KIND_START;
        it.s = 6'($urandom_range(63));
        it.d = 6'($urandom_range(63));
        append_item(it);
    endtask

    // apb write, only while the block is quiet
    task automatic write_node_count(input int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NODE_COUNT_ADDR;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_count_reg = 7'(value);
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        @(posedge clk);
        while (items_to_send.size() != 0 || item_valid)
            @(posedge clk);
        @(negedge clk);
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        @(posedge clk);
    endtask

    // random graph: mostly in-range edges, some noise, ending in a search
    task automatic random_graph_phase(input int n_items);
        int pick;
        int n;
        pick = $urandom_range(9);
        if (pick == 0)
            write_node_count(64);
        else if (pick == 1)
            write_node_count($urandom_range(127));
        else
            write_node_count($urandom_range(2, 12));
        n = live_nodes();
        for (int i = 0; i < n_items - 1; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_start();
            else if (pick < 20)
                send_edge($urandom_range(63), $urandom_range(63));
            else
                send_edge($urandom_range(n - 1), $urandom_range(n - 1));
        end
        send_start();
        wait_quiet();
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // single node graph, self loop, refused endpoints, ignored start fields
        write_node_count(1);
        send_start();
        send_edge(0, 0);
        send_edge(1, 0);
        send_edge(0, 1);
        send_start();
        wait_quiet();

        // zero count behaves as one
        write_node_count(0);
        send_edge(0, 1);
        send_start();
        wait_quiet();

        // tree, back edge, cross edge, self loop, out of range endpoints
        write_node_count(5);
        send_edge(0, 1);
        send_edge(0, 2);
        send_edge(1, 3);
        send_edge(3, 0);
        send_edge(2, 3);
        send_edge(4, 4);
        send_edge(5, 0);
        send_edge(0, 5);
        send_start();
        wait_quiet();

        // count above the maximum clamps to 64
        write_node_count(127);
        send_edge(63, 0);
        send_edge(0, 63);
        send_edge(63, 63);
        send_start();
        wait_quiet();

        // lowered count: stored edges to high nodes are skipped
        write_node_count(3);
        send_start();
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 38;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_graph_phase(12);
        end

        // long receiver hold-off while a run of edges waits at the input
        write_node_count(64);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_edge($urandom_range(63), $urandom_range(63));
        send_start();
        wait_quiet();

        write_node_count(8);
        send_edge(7, 0);
        send_start();
        wait_quiet();

        repeat (20) @(negedge clk);
        $display("covered %0d transactions: %0d edges kept, %0d refused, %0d searches",
                 items_taken, edges_kept, edges_refused, searches);
        $display("%0d finish reports checked, %0d mismatches", finish_reports, mismatches);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/core/gdfs_pkg.sv
rtl/core/gdfs_ctrl.sv
rtl/core/gdfs_dp.sv
rtl/core/graph_dfs_postorder.sv
test/tb.sv
